[hw/rtl/lsfe_pkg.sv]
// Shared types and constants for the LED strip fade engine.
`default_nettype none
package lsfe_pkg;

  localparam int PIXELS     = 32;
  localparam int EMIT       = (PIXELS < 32) ? PIXELS : 32;
  localparam int PIX_W      = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int IDX_W      = 5;
  localparam int CMP_W      = 7;
  localparam int CH_W       = 8;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CH_W-1:0] PIX_STEP_RST = 8'd20;
  localparam logic [CH_W-1:0] COL_STEP_RST = 8'd1;
  localparam logic [CH_W-1:0] FADE_STEP_RST = 8'd1;

  typedef enum logic [1:0] {
    ACT_PIXEL = 2'd0,
    ACT_ALL   = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIX_STEP = 1'b0,
    REG_COL_STEP = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic             shift;
    logic             wr_pix;
    logic             set_all;
    logic [IDX_W-1:0] idx;
    rgb_t             rgb;
    logic             fast;
    logic             last;
  } cell_cmd_t;

endpackage
`default_nettype wire

[hw/rtl/led_strip_fade_engine_top.sv]
// Top level of the LED strip fade engine: command decode, cell ring, output register.
//
// Input channel (in_*): one word per command. tuser selects the action: pixel
// target write, set-all write, tick or none. Pixel and set-all writes give no
// output; in_tready stays high for them.
// A tick rotates the ring of pixel cells once: each cycle that the output is
// not stalled, the pixel at the head passes through the fader, goes to the
// output register and re-enters at the tail. Accepting the tick sets busy_r,
// and the rotation then loads the first pixel word into the output register;
// in_tready is low until the rotation has finished.
// Output channel (out_*): one word per pixel, index order; tlast marks the last
// pixel, tuser on that word is set when every channel matched its target
// before the tick. With out_tready low the ring holds still and the word holds.
// Configuration channel (cfg_*): always ready, one register per write; write
// only while the block is idle.
// Reset (rst_n low, synchronous) clears all colours, sets the fade step to 1
// and restores the register defaults; no clearing pass is needed.
`default_nettype none
module led_strip_fade_engine_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // in_tdata: pixel_index[4:0], red[12:5], green[20:13], blue[28:21], fast[29]
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [lsfe_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser: action[1:0]
  input  wire logic [1:0]                         in_tuser,
  input  wire logic                               in_tlast,
  // out_tdata: out_index[4:0], out_red[12:5], out_green[20:13], out_blue[28:21]
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [lsfe_pkg::OUT_DATA_W-1:0]         out_tdata,
  // out_tuser: all_settled[0]
  output logic [0:0]                              out_tuser,
  output logic                                    out_tlast,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [lsfe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lsfe_pkg::CH_W-1:0]          cfg_data
);

  localparam int P = lsfe_pkg::PIXELS;

  lsfe_pkg::action_t   act;
  lsfe_pkg::cell_cmd_t cmd;
  lsfe_pkg::rgb_t      in_rgb;
  lsfe_pkg::rgb_t      cell_cur [P];
  lsfe_pkg::rgb_t      cell_tgt [P];
  lsfe_pkg::rgb_t      faded;
  logic [P-1:0]        cell_match;

  logic                       busy_r, busy_nxt;
  logic [lsfe_pkg::PIX_W-1:0] cnt_r, cnt_nxt;
  logic                       settled_r, settled_nxt;
  logic [lsfe_pkg::CH_W-1:0]  step_r, step_nxt;
  logic [lsfe_pkg::CH_W-1:0]  pix_step_r, pix_step_nxt;
  logic [lsfe_pkg::CH_W-1:0]  col_step_r, col_step_nxt;
  logic                       out_valid_r, out_valid_nxt;
  lsfe_pkg::rgb_t             out_rgb_r;
  logic [lsfe_pkg::IDX_W-1:0] out_idx_r;
  logic                       out_last_r;
  logic                       out_settled_r;

  logic in_acc;
  logic step_en;
  logic emit;
  logic emit_end;
  logic last_step;

  assign act          = lsfe_pkg::action_t'(in_tuser);
  assign in_rgb.red   = in_tdata[12:5];
  assign in_rgb.green = in_tdata[20:13];
  assign in_rgb.blue  = in_tdata[28:21];

  assign in_tready = !busy_r;
  assign in_acc    = in_tvalid && in_tready;
  assign step_en   = busy_r && (!out_valid_r || out_tready);
  assign emit      = lsfe_pkg::CMP_W'(cnt_r) < lsfe_pkg::CMP_W'(lsfe_pkg::EMIT);
  assign emit_end  = lsfe_pkg::CMP_W'(cnt_r) == lsfe_pkg::CMP_W'(lsfe_pkg::EMIT - 1);
  assign last_step = lsfe_pkg::CMP_W'(cnt_r) == lsfe_pkg::CMP_W'(P - 1);

  always_comb begin
    cmd.shift   = step_en;
    cmd.wr_pix  = in_acc && (act == lsfe_pkg::ACT_PIXEL);
    cmd.set_all = in_acc && (act == lsfe_pkg::ACT_ALL);
    cmd.idx     = in_tdata[4:0];
    cmd.rgb     = in_rgb;
    cmd.fast    = in_tdata[29];
    cmd.last    = in_tlast;
  end

  // ring: head is cell 0, faded pixel re-enters at the tail
  for (genvar i = 0; i < P; i++) begin : g_cell
    lsfe_pkg::rgb_t sh_cur;
    lsfe_pkg::rgb_t sh_tgt;
    if (i == P - 1) begin : g_tail
      assign sh_cur = faded;
      assign sh_tgt = cell_tgt[0];
    end else begin : g_mid
      assign sh_cur = cell_cur[i+1];
      assign sh_tgt = cell_tgt[i+1];
    end
    lsfe_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .my_idx  (lsfe_pkg::PIX_W'(i)),
      .cur_in  (sh_cur),
      .tgt_in  (sh_tgt),
      .cur_o   (cell_cur[i]),
      .tgt_o   (cell_tgt[i]),
      .match_o (cell_match[i])
    );
  end

  lsfe_fader u_fader (
    .cur_i  (cell_cur[0]),
    .tgt_i  (cell_tgt[0]),
    .step_i (step_r),
    .cur_o  (faded)
  );

  always_comb begin
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    settled_nxt   = settled_r;
    step_nxt      = step_r;
    pix_step_nxt  = pix_step_r;
    col_step_nxt  = col_step_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (cfg_valid && cfg_ready) begin
      unique case (lsfe_pkg::cfg_reg_t'(cfg_index))
        lsfe_pkg::REG_PIX_STEP: pix_step_nxt = cfg_data;
        lsfe_pkg::REG_COL_STEP: col_step_nxt = cfg_data;
        default: ;
      endcase
    end

    if (in_acc) begin
      unique case (act)
        lsfe_pkg::ACT_PIXEL: step_nxt = pix_step_r;
        lsfe_pkg::ACT_ALL:   step_nxt = col_step_r;
        lsfe_pkg::ACT_TICK: begin
          busy_nxt    = 1'b1;
          cnt_nxt     = '0;
          settled_nxt = &cell_match;
        end
        lsfe_pkg::ACT_NONE: ;
        default: ;
      endcase
    end

    if (step_en) begin
      if (emit) out_valid_nxt = 1'b1;
      if (last_step) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      settled_r   <= 1'b0;
      step_r      <= lsfe_pkg::FADE_STEP_RST;
      pix_step_r  <= lsfe_pkg::PIX_STEP_RST;
      col_step_r  <= lsfe_pkg::COL_STEP_RST;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      settled_r   <= settled_nxt;
      step_r      <= step_nxt;
      pix_step_r  <= pix_step_nxt;
      col_step_r  <= col_step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && emit) begin
      out_rgb_r     <= faded;
      out_idx_r     <= lsfe_pkg::IDX_W'(cnt_r);
      out_last_r    <= emit_end;
      out_settled_r <= emit_end && settled_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_rgb_r.blue, out_rgb_r.green, out_rgb_r.red, out_idx_r};
  assign out_tuser  = out_settled_r;
  assign out_tlast  = out_last_r;
  assign cfg_ready  = 1'b1;

endmodule
`default_nettype wire

[hw/rtl/lsfe_cell.sv]
// One pixel cell of the ring: current and target colour, local writes, shift.
`default_nettype none
module lsfe_cell (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire lsfe_pkg::cell_cmd_t     cmd,
  input  wire logic [lsfe_pkg::PIX_W-1:0] my_idx,
  input  wire lsfe_pkg::rgb_t          cur_in,
  input  wire lsfe_pkg::rgb_t          tgt_in,
  output lsfe_pkg::rgb_t               cur_o,
  output lsfe_pkg::rgb_t               tgt_o,
  output logic                         match_o
);

  lsfe_pkg::rgb_t cur_r, cur_nxt;
  lsfe_pkg::rgb_t tgt_r, tgt_nxt;
  logic           hit;
  logic           above;

  assign hit   = lsfe_pkg::CMP_W'(my_idx) == lsfe_pkg::CMP_W'(cmd.idx);
  assign above = lsfe_pkg::CMP_W'(my_idx) >  lsfe_pkg::CMP_W'(cmd.idx);

  always_comb begin
    cur_nxt = cur_r;
    tgt_nxt = tgt_r;
    if (cmd.shift) begin
      cur_nxt = cur_in;
      tgt_nxt = tgt_in;
    end else if (cmd.wr_pix) begin
      if (hit) begin
        tgt_nxt = cmd.rgb;
        if (cmd.fast) begin
          if (cmd.rgb.red   > cur_r.red)   cur_nxt.red   = cmd.rgb.red;
          if (cmd.rgb.green > cur_r.green) cur_nxt.green = cmd.rgb.green;
          if (cmd.rgb.blue  > cur_r.blue)  cur_nxt.blue  = cmd.rgb.blue;
        end
      end else if (cmd.last && above) begin
        tgt_nxt = '0;
      end
    end else if (cmd.set_all) begin
      tgt_nxt = cmd.rgb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      tgt_r <= '0;
    end else begin
      cur_r <= cur_nxt;
      tgt_r <= tgt_nxt;
    end
  end

  assign cur_o   = cur_r;
  assign tgt_o   = tgt_r;
  assign match_o = (cur_r == tgt_r);

endmodule
`default_nettype wire

[hw/rtl/lsfe_fader.sv]
// Fade stage at the head of the ring: moves each channel toward target by the step.
`default_nettype none
module lsfe_fader (
  input  wire lsfe_pkg::rgb_t               cur_i,
  input  wire lsfe_pkg::rgb_t               tgt_i,
  input  wire logic [lsfe_pkg::CH_W-1:0]    step_i,
  output lsfe_pkg::rgb_t                    cur_o
);

  function automatic logic [lsfe_pkg::CH_W-1:0] approach(
    input logic [lsfe_pkg::CH_W-1:0] now,
    input logic [lsfe_pkg::CH_W-1:0] goal,
    input logic [lsfe_pkg::CH_W-1:0] step
  );
    logic [lsfe_pkg::CH_W-1:0] gap;
    logic [lsfe_pkg::CH_W-1:0] res;
    if (goal > now) begin
      gap = goal - now;
      res = (gap < step) ? goal : now + step;
    end else begin
      gap = now - goal;
      res = (gap < step) ? goal : now - step;
    end
    return res;
  endfunction

  assign cur_o.red   = approach(cur_i.red,   tgt_i.red,   step_i);
  assign cur_o.green = approach(cur_i.green, tgt_i.green, step_i);
  assign cur_o.blue  = approach(cur_i.blue,  tgt_i.blue,  step_i);

endmodule
`default_nettype wire

[hw/rtl/lsfe_checker.sv]
// Port-level checks for the fade engine, bound to the top level.
`default_nettype none
module lsfe_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic [1:0]                     in_tuser,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [lsfe_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [0:0]                     out_tuser,
  input wire logic                           out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == lsfe_pkg::ACT_TICK) |=> !in_tready)
    else $error("input still ready after a tick was taken");

  a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == lsfe_pkg::ACT_PIXEL ||
      in_tuser == lsfe_pkg::ACT_ALL) |=> in_tready)
    else $error("write made the block busy");

  a_settled_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("settled flag away from last pixel");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |->
      out_tdata[4:0] == lsfe_pkg::IDX_W'(lsfe_pkg::EMIT - 1))
    else $error("last flag on wrong pixel");

endmodule

bind led_strip_fade_engine_top lsfe_checker u_lsfe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the LED strip fade engine: directed and random command words.
`default_nettype none
module testbench;
  import lsfe_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    logic [IDX_W-1:0] index;
    rgb_t             colour;
    logic             eof;
    logic             settled;
  } pixel_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = ACT_NONE;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0] out_tuser;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_PIX_STEP;
  logic [CH_W-1:0] cfg_data = '0;

  // shadow of the strip
  rgb_t now_colour[PIXELS];
  rgb_t goal_colour[PIXELS];
  logic [CH_W-1:0] active_step = FADE_STEP_RST;
  logic [CH_W-1:0] pixel_step = PIX_STEP_RST;
  logic [CH_W-1:0] colour_step = COL_STEP_RST;

  pixel_word_t frame_q[$];
  int errors = 0;
  int send_idle_pct = 9;
  int recv_idle_pct = 86;
  int quiet_cycles = 0;

  led_strip_fade_engine_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    for (int i = 0; i < PIXELS; i++) begin
      now_colour[i] = '0;
      goal_colour[i] = '0;
    end
  end

  function automatic logic [CH_W-1:0] fade_toward(logic [CH_W-1:0] level,
                                                  logic [CH_W-1:0] goal,
                                                  logic [CH_W-1:0] step);
    if (goal > level)
      return (goal - level < step) ? goal : level + step;
    return (level - goal < step) ? goal : level - step;
  endfunction

  // update the shadow for one accepted word; queue the frame on a tick
  task automatic predict_word(action_t act, logic [IDX_W-1:0] idx, rgb_t col,
                              logic fast, logic last);
    logic settled;
    pixel_word_t w;
    settled = 1'b1;
    case (act)
      ACT_PIXEL: begin
        active_step = pixel_step;
        if (int'(idx) < PIXELS) begin
          goal_colour[idx] = col;
          if (fast && col.red > now_colour[idx].red) now_colour[idx].red = col.red;
          if (fast && col.green > now_colour[idx].green) now_colour[idx].green = col.green;
          if (fast && col.blue > now_colour[idx].blue) now_colour[idx].blue = col.blue;
          if (last)
            for (int i = int'(idx) + 1; i < PIXELS; i++) goal_colour[i] = '0;
        end
      end
      ACT_ALL: begin
        active_step = colour_step;
        for (int i = 0; i < PIXELS; i++) goal_colour[i] = col;
      end
      ACT_TICK: begin
        for (int i = 0; i < PIXELS; i++) begin
          if (now_colour[i] != goal_colour[i]) settled = 1'b0;
          now_colour[i].red = fade_toward(now_colour[i].red, goal_colour[i].red,
                                          active_step);
          now_colour[i].green = fade_toward(now_colour[i].green, goal_colour[i].green,
                                            active_step);
          now_colour[i].blue = fade_toward(now_colour[i].blue, goal_colour[i].blue,
                                           active_step);
        end
        for (int i = 0; i < EMIT; i++) begin
          w.index = i[IDX_W-1:0];
          w.colour = now_colour[i];
          w.eof = (i == EMIT - 1);
          w.settled = w.eof && settled;
          frame_q.push_back(w);
        end
      end
      default: ;
    endcase
  endtask

  // keeps tvalid high across back-to-back words; lowered only when idling
  task automatic send_word(action_t act, logic [IDX_W-1:0] idx, rgb_t col,
                           logic fast, logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, fast, col.blue, col.green, col.red, idx};
    in_tuser <= act;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    predict_word(act, idx, col, fast, last);
  endtask

  task automatic wait_drained;
    in_tvalid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_steps(logic [CH_W-1:0] pix, logic [CH_W-1:0] col);
    cfg_reg_t r;
    for (int k = 0; k < 2; k++) begin
      r = (k == 0) ? REG_PIX_STEP : REG_COL_STEP;
      cfg_valid <= 1'b1;
      cfg_index <= r;
      cfg_data <= (k == 0) ? pix : col;
      do @(posedge clk); while (!cfg_ready);
      if (r == REG_PIX_STEP) pixel_step = pix;
      else colour_step = col;
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CH_W-1:0] pick_level;
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return CH_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [CH_W-1:0] pick_step;
    case ($urandom_range(3))
      0: return 8'd1;
      1: return 8'd255;
      2: return CH_W'($urandom_range(255, 16));
      default: return CH_W'($urandom_range(255, 1));
    endcase
  endfunction

  function automatic rgb_t pick_colour;
    rgb_t c;
    c.red = pick_level();
    c.green = pick_level();
    c.blue = pick_level();
    return c;
  endfunction

  task automatic test_tick_after_reset;
    send_word(ACT_TICK, 5'd31, '{8'hFF, 8'hFF, 8'hFF}, 1'b1, 1'b1);
  endtask

  task automatic test_pixel_writes;
    send_word(ACT_PIXEL, 5'd0, '{8'hFF, 8'hFF, 8'hFF}, 1'b1, 1'b0);
    send_word(ACT_PIXEL, 5'd31, '{8'h00, 8'h80, 8'hFF}, 1'b0, 1'b0);
    send_word(ACT_PIXEL, 5'd16, '{8'h55, 8'hAA, 8'h01}, 1'b1, 1'b0);
    send_word(ACT_TICK, 5'd0, '{8'h00, 8'h00, 8'h00}, 1'b0, 1'b0);
    send_word(ACT_PIXEL, 5'd20, '{8'h10, 8'h20, 8'h30}, 1'b0, 1'b1);
    send_word(ACT_NONE, 5'd7, '{8'hFF, 8'hFF, 8'hFF}, 1'b1, 1'b1);
    send_word(ACT_TICK, 5'd10, '{8'h12, 8'h34, 8'h56}, 1'b0, 1'b1);
    send_word(ACT_PIXEL, 5'd0, '{8'h00, 8'h00, 8'h00}, 1'b1, 1'b1);
    send_word(ACT_TICK, 5'd0, '{8'h00, 8'h00, 8'h00}, 1'b0, 1'b0);
    send_word(ACT_TICK, 5'd0, '{8'h00, 8'h00, 8'h00}, 1'b0, 1'b0);
  endtask

  task automatic test_step_registers;
    wait_drained();
    write_steps(8'd255, 8'd255);
    send_word(ACT_ALL, 5'd31, '{8'hFF, 8'hFF, 8'hFF}, 1'b1, 1'b1);
    send_word(ACT_TICK, 5'd0, '{8'h00, 8'h00, 8'h00}, 1'b0, 1'b0);
    send_word(ACT_TICK, 5'd0, '{8'h00, 8'h00, 8'h00}, 1'b0, 1'b0);
    wait_drained();
    write_steps(8'd1, 8'd1);
    send_word(ACT_PIXEL, 5'd3, '{8'h80, 8'h80, 8'h80}, 1'b0, 1'b0);
    send_word(ACT_TICK, 5'd0, '{8'h00, 8'h00, 8'h00}, 1'b0, 1'b0);
    // zero step: unsettled channels stay put
    wait_drained();
    write_steps(8'd0, 8'd0);
    send_word(ACT_PIXEL, 5'd9, '{8'h40, 8'h00, 8'hC0}, 1'b0, 1'b0);
    send_word(ACT_TICK, 5'd0, '{8'h00, 8'h00, 8'h00}, 1'b0, 1'b0);
  endtask

  task automatic test_random_traffic(int s_idle, int r_idle, int items);
    int n;
    int pick;
    rgb_t col;
    n = 0;
    wait_drained();
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    write_steps(pick_step(), pick_step());
    while (n < items) begin
      if (n == items / 2) wait_drained();
      pick = $urandom_range(99);
      col = pick_colour();
      if (pick < 42)
        send_word(ACT_PIXEL, IDX_W'($urandom_range(31)), col, 1'($urandom_range(1)),
                  $urandom_range(7) == 0);
      else if (pick < 52)
        send_word(ACT_ALL, IDX_W'($urandom_range(31)), col, 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      else if (pick < 90)
        send_word(ACT_TICK, IDX_W'($urandom_range(31)), col, 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      else
        send_word(ACT_NONE, IDX_W'($urandom_range(31)), col, 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      if (pick < 90) n++;
    end
  endtask

  task automatic note_mismatch(string field, int unsigned exp, int unsigned act);
    errors++;
    if (errors <= 10)
      $display("mismatch on %s: expected %0h, got %0h", field, exp, act);
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    pixel_word_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: tdata %0h", out_tdata);
      end else begin
        e = frame_q.pop_front();
        if (out_tdata[4:0] !== e.index) note_mismatch("index", e.index, out_tdata[4:0]);
        if (out_tdata[12:5] !== e.colour.red)
          note_mismatch("red", e.colour.red, out_tdata[12:5]);
        if (out_tdata[20:13] !== e.colour.green)
          note_mismatch("green", e.colour.green, out_tdata[20:13]);
        if (out_tdata[28:21] !== e.colour.blue)
          note_mismatch("blue", e.colour.blue, out_tdata[28:21]);
        if (out_tlast !== e.eof) note_mismatch("end_of_frame", e.eof, out_tlast);
        if (out_tuser[0] !== e.settled)
          note_mismatch("all_settled", e.settled, out_tuser[0]);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_tick_after_reset();
    test_pixel_writes();
    test_step_registers();
    test_random_traffic(9, 86, 50);
    test_random_traffic(86, 9, 50);
    test_random_traffic(0, 0, 50);
    in_tvalid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
